// ===== hdl/arp_pkg.sv =====
// arp cache resolver package: sizes, codes, state and memory entry types
// no dependencies
`default_nettype none
package arp_pkg;
  localparam int ENTRIES     = 32;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int STAMP_WIDTH = 32;

  typedef enum logic [1:0] {
    CMD_RX      = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ANSWER  = 2'd0,
    KIND_STATUS  = 2'd1,
    KIND_REQUEST = 2'd2,
    KIND_REPLY   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_FOUND      = 3'd0,
    STS_INCOMPLETE = 3'd1,
    STS_ACCEPTED   = 3'd2,
    STS_SHORT      = 3'd3,
    STS_BAD_HW     = 3'd4,
    STS_BAD_PROTO  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ES_FREE       = 2'd0,
    ES_INCOMPLETE = 2'd1,
    ES_RESOLVED   = 2'd2,
    ES_STATIC     = 2'd3
  } estate_t;

  typedef enum logic [1:0] {
    CFG_LOCAL_IP  = 2'd0,
    CFG_LOCAL_MAC = 2'd1,
    CFG_IP_EN     = 2'd2,
    CFG_TIMEOUT   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_SCAN_LAST,
    S_DECIDE,
    S_OUT1,
    S_OUT2
  } fsm_t;

  typedef struct packed {
    logic [1:0]             st;
    logic [31:0]            ip;
    logic [47:0]            mac;
    logic [STAMP_WIDTH-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [47:0] rmac;
    logic [31:0] tip;
    logic [47:0] tmac;
    logic [47:0] dmac;
    logic        last;
  } result_t;

  localparam logic [47:0] BROADCAST = 48'hFFFF_FFFF_FFFF;
endpackage
`default_nettype wire

// ===== hdl/arp_table.sv =====
// arp cache entry memory: one write port, one registered read port
// depends on arp_pkg
`default_nettype none
module arp_table (
  input  wire                    clk,
  input  wire                    we,
  input  wire [arp_pkg::IDX_W-1:0] waddr,
  input  arp_pkg::entry_t        wdata,
  input  wire [arp_pkg::IDX_W-1:0] raddr,
  output arp_pkg::entry_t        rdata
);
  import arp_pkg::*;
  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/arp_cache_resolver_top.sv =====
// arp cache resolver top level: control sequencer around the entry memory
// depends on arp_pkg and arp_table
`default_nettype none
// Every resolve, tick or well-formed receive walks the entry memory one entry a cycle through
// its single read port; write-backs happen during the walk or in a decide cycle after it. A
// receive or resolve leaves one or two result beats, a tick leaves none, a rejected message
// leaves one status beat without a walk and cmd 3 leaves nothing. After reset a clearing pass
// runs before the first item is taken. Results leave through one output register, and a new
// item is taken only once the previous item's results are gone.
module arp_cache_resolver_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_cmd,
  input  wire  [10:0] in_msg_len,
  input  wire  [15:0] in_hw_type,
  input  wire  [15:0] in_proto_type,
  input  wire  [7:0]  in_hw_len,
  input  wire  [7:0]  in_proto_len,
  input  wire  [15:0] in_opcode,
  input  wire  [47:0] in_sender_mac,
  input  wire  [31:0] in_sender_ip,
  input  wire  [31:0] in_target_ip_in,
  input  wire  [31:0] in_query_ip,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_status,
  output logic [47:0] out_resolved_mac,
  output logic [31:0] out_target_ip_out,
  output logic [47:0] out_target_mac_out,
  output logic [47:0] out_dest_mac,
  output logic        out_last,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [47:0] cfg_data
);
  import arp_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [31:0]            local_ip_r;
  logic [47:0]            local_mac_r;
  logic                   ip_en_r;
  logic [15:0]            timeout_r;
  logic [STAMP_WIDTH-1:0] now_r, now_nxt;

  fsm_t state_r, state_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [15:0] op_r, op_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic        us_r, us_nxt;

  logic [IDX_W-1:0] raddr_r, raddr_nxt;   // address being read
  logic [IDX_W-1:0] cidx_r, cidx_nxt;     // address of data arriving now
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hidx_r, hidx_nxt;
  entry_t           hent_r, hent_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  logic [IDX_W-1:0] oidx_r, oidx_nxt;
  logic [STAMP_WIDTH-1:0] oage_r, oage_nxt;

  result_t res_r, res_nxt, res2_r, res2_nxt;
  logic    two_r, two_nxt;
  logic    ov_r, ov_nxt;

  logic   we;
  logic [IDX_W-1:0] waddr;
  entry_t wdata, rd;

  arp_table u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr_r),
    .rdata(rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r  <= '0;
      local_mac_r <= '0;
      ip_en_r     <= 1'b0;
      timeout_r   <= 16'd30;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOCAL_IP:  local_ip_r  <= cfg_data[31:0];
        CFG_LOCAL_MAC: local_mac_r <= cfg_data;
        CFG_IP_EN:     ip_en_r     <= cfg_data[0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data[15:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      raddr_r <= '0;
      now_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      raddr_r <= raddr_nxt;
      now_r   <= now_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;   op_r   <= op_nxt;   mac_r  <= mac_nxt;
    ip_r   <= ip_nxt;    us_r   <= us_nxt;   cidx_r <= cidx_nxt;
    hit_r  <= hit_nxt;   hidx_r <= hidx_nxt; hent_r <= hent_nxt;
    free_r <= free_nxt;  fidx_r <= fidx_nxt; oidx_r <= oidx_nxt;
    oage_r <= oage_nxt;  res_r  <= res_nxt;  res2_r <= res2_nxt;
    two_r  <= two_nxt;
  end

  function automatic result_t mk(kind_t k, status_t s, logic [47:0] rm,
                                 logic [31:0] ti, logic [47:0] tm,
                                 logic [47:0] dm, logic l);
    result_t r;
    r.kind = k; r.status = s; r.rmac = rm; r.tip = ti;
    r.tmac = tm; r.dmac = dm; r.last = l;
    return r;
  endfunction

  logic                   rd_used;
  logic [STAMP_WIDTH-1:0] age;
  entry_t                 new_e;
  logic [IDX_W-1:0]       aidx;

  always_comb begin
    state_nxt = state_r;  raddr_nxt = raddr_r; now_nxt = now_r;
    cmd_nxt = cmd_r; op_nxt = op_r; mac_nxt = mac_r; ip_nxt = ip_r;
    us_nxt = us_r; cidx_nxt = raddr_r; hit_nxt = hit_r; hidx_nxt = hidx_r;
    hent_nxt = hent_r; free_nxt = free_r; fidx_nxt = fidx_r;
    oidx_nxt = oidx_r; oage_nxt = oage_r; res_nxt = res_r; res2_nxt = res2_r;
    two_nxt = two_r; ov_nxt = ov_r;
    we = 1'b0; waddr = cidx_r; wdata = '0;
    in_ready = 1'b0;
    rd_used = 1'b0;
    age = now_r - rd.stamp;
    new_e = '0;
    aidx = free_r ? fidx_r : oidx_r;

    if (ov_r && out_ready) begin
      if (two_r) begin
        res_nxt = res2_r;
        two_nxt = 1'b0;
      end else begin
        ov_nxt = 1'b0;
      end
    end

    case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = raddr_r; wdata = '0;
        raddr_nxt = raddr_r + 1'b1;
        if (raddr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
          raddr_nxt = '0;
        end
      end
      S_IDLE: begin
        in_ready = !ov_r;
        raddr_nxt = '0;
        if (in_valid && !ov_r) begin
          cmd_nxt = in_cmd; op_nxt = in_opcode; mac_nxt = in_sender_mac;
          ip_nxt  = (in_cmd == CMD_RESOLVE) ? in_query_ip : in_sender_ip;
          us_nxt  = ip_en_r && (local_ip_r == in_target_ip_in);
          hit_nxt = 1'b0; free_nxt = 1'b0; oidx_nxt = '0; oage_nxt = '0;
          two_nxt = 1'b0;
          raddr_nxt = IDX_W'(1);
          state_nxt = S_SCAN;
          case (cmd_t'(in_cmd))
            CMD_RX: begin
              if (in_msg_len < 11'd28) begin
                res_nxt = mk(KIND_STATUS, STS_SHORT, '0, '0, '0, '0, 1'b1);
                ov_nxt = 1'b1; state_nxt = S_IDLE;
              end else if (in_hw_type != 16'h0001 || in_hw_len != 8'd6) begin
                res_nxt = mk(KIND_STATUS, STS_BAD_HW, '0, '0, '0, '0, 1'b1);
                ov_nxt = 1'b1; state_nxt = S_IDLE;
              end else if (in_proto_type != 16'h0800 || in_proto_len != 8'd4) begin
                res_nxt = mk(KIND_STATUS, STS_BAD_PROTO, '0, '0, '0, '0, 1'b1);
                ov_nxt = 1'b1; state_nxt = S_IDLE;
              end
            end
            CMD_RESOLVE: ;
            CMD_TICK: now_nxt = now_r + 1'b1;
            default: state_nxt = S_IDLE;
          endcase
          if (state_nxt == S_IDLE) raddr_nxt = '0;
        end
      end
      S_SCAN, S_SCAN_LAST: begin
        // data for cidx_r arrives now; addresses move one a cycle
        rd_used = 1'b1;
        raddr_nxt = raddr_r + 1'b1;
        if (cmd_r == CMD_TICK) begin
          if (rd.st != ES_FREE && rd.st != ES_STATIC &&
              age > STAMP_WIDTH'(timeout_r)) begin
            we = 1'b1; waddr = cidx_r; wdata = '0;
          end
        end else begin
          if (rd.st != ES_FREE && rd.ip == ip_r && !hit_r) begin
            hit_nxt = 1'b1; hidx_nxt = cidx_r; hent_nxt = rd;
          end
          if (rd.st == ES_FREE && !free_r) begin
            free_nxt = 1'b1; fidx_nxt = cidx_r;
          end
          if (cidx_r == '0 || age > oage_r) begin
            oidx_nxt = cidx_r; oage_nxt = age;
          end
        end
        if (state_r == S_SCAN_LAST) begin
          state_nxt = (cmd_r == CMD_TICK) ? S_IDLE : S_DECIDE;
          raddr_nxt = '0;
        end else if (raddr_r == LAST_IDX) begin
          state_nxt = S_SCAN_LAST;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        ov_nxt = 1'b1;
        if (cmd_r == CMD_RX) begin
          res_nxt = mk(KIND_STATUS, STS_ACCEPTED, '0, '0, '0, '0, 1'b1);
          new_e.st = ES_RESOLVED; new_e.ip = ip_r; new_e.mac = mac_r;
          new_e.stamp = now_r;
          if (hit_r) begin
            we = 1'b1; waddr = hidx_r; wdata = new_e;
          end else if (us_r) begin
            we = 1'b1; waddr = aidx; wdata = new_e;
          end
          if (us_r && op_r == 16'd1) begin
            res_nxt  = mk(KIND_REPLY, STS_FOUND, '0, ip_r, mac_r, mac_r, 1'b0);
            res2_nxt = mk(KIND_STATUS, STS_ACCEPTED, '0, '0, '0, '0, 1'b1);
            two_nxt  = 1'b1;
          end
        end else begin
          if (!hit_r) begin
            new_e.st = ES_INCOMPLETE; new_e.ip = ip_r; new_e.stamp = now_r;
            we = 1'b1; waddr = aidx; wdata = new_e;
          end
          if (!hit_r || hent_r.st == ES_INCOMPLETE) begin
            res_nxt  = mk(KIND_REQUEST, STS_FOUND, '0, ip_r, '0, BROADCAST, 1'b0);
            res2_nxt = mk(KIND_ANSWER, STS_INCOMPLETE, '0, '0, '0, '0, 1'b1);
            two_nxt  = 1'b1;
          end else begin
            res_nxt = mk(KIND_ANSWER, STS_FOUND, hent_r.mac, '0, '0, '0, 1'b1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid          = ov_r;
  assign out_kind           = res_r.kind;
  assign out_status         = res_r.status;
  assign out_resolved_mac   = res_r.rmac;
  assign out_target_ip_out  = res_r.tip;
  assign out_target_mac_out = res_r.tmac;
  assign out_dest_mac       = res_r.dmac;
  assign out_last           = res_r.last;

  logic unused_ok;
  assign unused_ok = rd_used | (|local_mac_r);
endmodule
`default_nettype wire

// ===== hdl/arp_checker.sv =====
// port-level checks on the arp cache resolver
// depends on arp_pkg; bound to arp_cache_resolver_top
`default_nettype none
module arp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_kind,
  input wire [47:0] out_dest_mac,
  input wire        out_last
);
  import arp_pkg::*;

  // nothing taken while a result beat still waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // an offered input beat is held until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("input beat dropped");

  // request and reply beats are never the final one
  a_send_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_REQUEST || out_kind == KIND_REPLY) |-> !out_last)
    else $error("send beat flagged last");

  // a request goes to broadcast
  a_req_bcast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REQUEST |-> out_dest_mac == BROADCAST)
    else $error("request not broadcast");

  // a non-final beat is followed by another
  a_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("missing final beat");
endmodule

bind arp_cache_resolver_top arp_checker u_arp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
  .out_dest_mac(out_dest_mac), .out_last(out_last)
);
`default_nettype wire

// ===== test/arp_cache_resolver_top_tb.sv =====
// testbench for the arp cache resolver: directed and random receive, resolve and tick beats
// checked against an in-bench cache predictor; depends on arp_pkg and the rtl top level
`default_nettype none
module arp_cache_resolver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = '0;
  logic [10:0] in_msg_len = '0;
  logic [15:0] in_hw_type = '0;
  logic [15:0] in_proto_type = '0;
  logic [7:0]  in_hw_len = '0;
  logic [7:0]  in_proto_len = '0;
  logic [15:0] in_opcode = '0;
  logic [47:0] in_sender_mac = '0;
  logic [31:0] in_sender_ip = '0;
  logic [31:0] in_target_ip_in = '0;
  logic [31:0] in_query_ip = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [2:0]  out_status;
  logic [47:0] out_resolved_mac;
  logic [31:0] out_target_ip_out;
  logic [47:0] out_target_mac_out;
  logic [47:0] out_dest_mac;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  arp_cache_resolver_top uut (.*);

  always #6 clk = ~clk;

  typedef struct {
    logic [1:0]  cmd;
    logic [10:0] len;
    logic [15:0] hwt;
    logic [15:0] prt;
    logic [7:0]  hln;
    logic [7:0]  pln;
    logic [15:0] op;
    logic [47:0] sha;
    logic [31:0] spa;
    logic [31:0] tpa;
    logic [31:0] qip;
  } arp_item_t;

  // predictor state
  logic [1:0]  c_st [ENTRIES];
  logic [31:0] c_ip [ENTRIES];
  logic [47:0] c_mac [ENTRIES];
  logic [31:0] c_stamp [ENTRIES];
  logic [31:0] now_ticks;
  logic [31:0] my_ip;
  logic [47:0] my_mac;
  logic        ip_on;
  logic [15:0] age_limit;

  result_t pending_results [$];
  int errors = 0;
  bit quiet = 1'b0;
  logic [31:0] ip_pool [8];

  function automatic result_t mk(kind_t k, status_t s, logic [47:0] rm, logic [31:0] ti,
                                 logic [47:0] tm, logic [47:0] dm, logic l);
    result_t r;
    r.kind = k; r.status = s; r.rmac = rm; r.tip = ti; r.tmac = tm; r.dmac = dm; r.last = l;
    return r;
  endfunction

  function automatic int lookup(logic [31:0] ip);
    for (int i = 0; i < ENTRIES; i++)
      if (c_st[i] != ES_FREE && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic void wipe(int i);
    c_st[i] = ES_FREE; c_ip[i] = '0; c_mac[i] = '0; c_stamp[i] = '0;
  endfunction

  function automatic int pick_victim();
    int p;
    p = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_st[i] == ES_FREE) return i;
      if (32'(now_ticks - c_stamp[i]) > 32'(now_ticks - c_stamp[p])) p = i;
    end
    wipe(p);
    return p;
  endfunction

  function automatic void predict_cache(arp_item_t it);
    int i;
    bit merged;
    merged = 0;
    case (it.cmd)
      CMD_RX: begin
        if (it.len < 28) pending_results.push_back(mk(KIND_STATUS, STS_SHORT, 0, 0, 0, 0, 1));
        else if (it.hwt != 16'h0001 || it.hln != 6)
          pending_results.push_back(mk(KIND_STATUS, STS_BAD_HW, 0, 0, 0, 0, 1));
        else if (it.prt != 16'h0800 || it.pln != 4)
          pending_results.push_back(mk(KIND_STATUS, STS_BAD_PROTO, 0, 0, 0, 0, 1));
        else begin
          i = lookup(it.spa);
          if (i >= 0) begin
            c_st[i] = ES_RESOLVED; c_mac[i] = it.sha; c_stamp[i] = now_ticks; merged = 1;
          end
          if (ip_on && my_ip == it.tpa) begin
            if (!merged) begin
              i = pick_victim();
              c_st[i] = ES_RESOLVED; c_ip[i] = it.spa; c_mac[i] = it.sha;
              c_stamp[i] = now_ticks;
            end
            if (it.op == 16'd1)
              pending_results.push_back(mk(KIND_REPLY, STS_FOUND, 0, it.spa, it.sha, it.sha, 0));
          end
          pending_results.push_back(mk(KIND_STATUS, STS_ACCEPTED, 0, 0, 0, 0, 1));
        end
      end
      CMD_RESOLVE: begin
        i = lookup(it.qip);
        if (i < 0) begin
          i = pick_victim();
          c_st[i] = ES_INCOMPLETE; c_ip[i] = it.qip; c_stamp[i] = now_ticks;
        end
        if (c_st[i] == ES_INCOMPLETE) begin
          pending_results.push_back(mk(KIND_REQUEST, STS_FOUND, 0, it.qip, 0, BROADCAST, 0));
          pending_results.push_back(mk(KIND_ANSWER, STS_INCOMPLETE, 0, 0, 0, 0, 1));
        end else
          pending_results.push_back(mk(KIND_ANSWER, STS_FOUND, c_mac[i], 0, 0, 0, 1));
      end
      CMD_TICK: begin
        now_ticks++;
        for (int k = 0; k < ENTRIES; k++)
          if (c_st[k] != ES_FREE && c_st[k] != ES_STATIC &&
              32'(now_ticks - c_stamp[k]) > 32'(age_limit)) wipe(k);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // result side: random stalls and checking
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) report_mismatch("unexpected beat", out_kind, 0);
        else begin
          e = pending_results.pop_front();
          if (out_kind != e.kind) report_mismatch("kind", out_kind, e.kind);
          if (out_status != e.status) report_mismatch("status", out_status, e.status);
          if (out_resolved_mac != e.rmac) report_mismatch("resolved_mac", out_resolved_mac, e.rmac);
          if (out_target_ip_out != e.tip) report_mismatch("target_ip", out_target_ip_out, e.tip);
          if (out_target_mac_out != e.tmac)
            report_mismatch("target_mac", out_target_mac_out, e.tmac);
          if (out_dest_mac != e.dmac) report_mismatch("dest_mac", out_dest_mac, e.dmac);
          if (out_last != e.last) report_mismatch("last", out_last, e.last);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // valid stays up between back-to-back beats; it drops only for a gap or at the end
  task automatic send_item(arp_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd; in_msg_len <= it.len; in_hw_type <= it.hwt; in_proto_type <= it.prt;
    in_hw_len <= it.hln; in_proto_len <= it.pln; in_opcode <= it.op;
    in_sender_mac <= it.sha; in_sender_ip <= it.spa; in_target_ip_in <= it.tpa;
    in_query_ip <= it.qip;
    do @(posedge clk); while (!in_ready);
    predict_cache(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 10) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [47:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOCAL_IP:  my_ip = v[31:0];
      CFG_LOCAL_MAC: my_mac = v;
      CFG_IP_EN:     ip_on = v[0];
      default:       age_limit = v[15:0];
    endcase
  endtask

  function automatic arp_item_t good_rx(logic [31:0] spa, logic [31:0] tpa, logic [15:0] op);
    arp_item_t it;
    it = '{CMD_RX, 11'd28, 16'h0001, 16'h0800, 8'd6, 8'd4, op, 48'({$urandom, $urandom}),
           spa, tpa, $urandom};
    return it;
  endfunction

  function automatic arp_item_t rand_item();
    arp_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it = good_rx(ip_pool[$urandom_range(0, 7)],
                 ($urandom_range(0, 2) != 0) ? my_ip : ip_pool[$urandom_range(0, 7)],
                 ($urandom_range(0, 3) != 0) ? 16'd1 : 16'($urandom_range(0, 65535)));
    it.len = 11'($urandom_range(28, 2047));
    it.qip = ($urandom_range(0, 3) != 0) ? ip_pool[$urandom_range(0, 7)] : $urandom;
    if (r < 35) it.cmd = CMD_RX;
    else if (r < 75) it.cmd = CMD_RESOLVE;
    else if (r < 88) it.cmd = CMD_TICK;
    else if (r < 90) it.cmd = CMD_NONE;
    else begin
      // broken or noisy message
      it.cmd = CMD_RX;
      case ($urandom_range(0, 3))
        0: it.len = 11'($urandom_range(0, 27));
        1: it.hwt = 16'($urandom);
        2: it.hln = 8'($urandom);
        default: begin it.prt = 16'($urandom); it.pln = 8'($urandom); end
      endcase
      if ($urandom_range(0, 3) == 0) begin
        it.len = 11'($urandom); it.hwt = 16'($urandom); it.prt = 16'($urandom);
        it.hln = 8'($urandom); it.pln = 8'($urandom); it.spa = $urandom; it.tpa = $urandom;
      end
    end
    return it;
  endfunction

  task automatic test_config();
    write_reg(CFG_LOCAL_IP, 48'hC0A8_0001);
    write_reg(CFG_LOCAL_MAC, 48'h0200_0000_0001);
    write_reg(CFG_IP_EN, 48'd1);
    write_reg(CFG_TIMEOUT, 48'd3);
  endtask

  task automatic test_rejects();
    arp_item_t it;
    it = good_rx(32'h1, my_ip, 16'd1);
    it.len = 11'd0; send_item(it);
    it.len = 11'd27; send_item(it);
    it.len = 11'd2047; it.hwt = 16'hFFFF; send_item(it);
    it.hwt = 16'h0001; it.hln = 8'hFF; send_item(it);
    it.hln = 8'd6; it.prt = 16'hFFFF; send_item(it);
    it.prt = 16'h0800; it.pln = 8'd0; send_item(it);
  endtask

  task automatic test_resolve_flow();
    arp_item_t it;
    it = good_rx(0, 0, 0);
    it.cmd = CMD_RESOLVE; it.qip = 32'hFFFF_FFFF; send_item(it);
    send_item(it);                                        // incomplete hit
    send_item(good_rx(32'hFFFF_FFFF, my_ip, 16'd2));      // reply fills entry
    send_item(it);                                        // found
    send_item(good_rx(32'h0, my_ip, 16'd1));              // request answered
    send_item(good_rx(32'h5, 32'h6, 16'd1));              // not for us
    send_item(good_rx(32'h7, my_ip, 16'hFFFF));           // unknown opcode
    it.cmd = CMD_NONE; send_item(it);
    it.cmd = CMD_TICK; repeat (5) send_item(it);          // ages out
    it.cmd = CMD_RESOLVE; it.qip = 32'h0; send_item(it);
  endtask

  task automatic test_full_cache();
    arp_item_t it;
    it = good_rx(0, 0, 0);
    it.cmd = CMD_RESOLVE;
    for (int i = 0; i < ENTRIES + 3; i++) begin
      it.qip = 32'h0A00_0000 + i; send_item(it);
    end
  endtask

  task automatic test_random(int n, logic [15:0] tmo, logic en);
    wait_idle();
    write_reg(CFG_TIMEOUT, {32'd0, tmo});
    write_reg(CFG_IP_EN, {47'd0, en});
    write_reg(CFG_LOCAL_IP, {16'd0, ($urandom_range(0, 1) != 0) ? ip_pool[0] : $urandom});
    write_reg(CFG_LOCAL_MAC, 48'({$urandom, $urandom}));
    for (int i = 0; i < n; i++) send_item(rand_item());
  endtask

  initial begin
    my_ip = '0; my_mac = '0; ip_on = 1'b0; age_limit = 16'd30; now_ticks = '0;
    for (int i = 0; i < ENTRIES; i++) wipe(i);
    for (int i = 0; i < 8; i++) ip_pool[i] = $urandom;
    ip_pool[1] = 32'h0; ip_pool[2] = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (ENTRIES + 4) @(posedge clk);
    test_config();
    test_rejects();
    test_resolve_flow();
    test_full_cache();
    test_random(120, 16'd30, 1'b1);
    test_random(100, 16'd0, 1'b1);
    test_random(100, 16'hFFFF, 1'b0);
    test_random(100, 16'd2, 1'b1);
    quiet = 1'b1;
    test_random(100, 16'd1, 1'b1);
    wait_idle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
